// File: sv/h2r_pkg.sv
// Shared types, widths and elaboration-time helpers for the HSV to RGB converter.
// No dependencies; every other file imports this package.
package h2r_pkg;

    localparam int HUE_FRAC_BITS_DEF = 6;
    localparam int HUE_W             = 15;
    localparam int FRAC_W            = 16;
    localparam int COMP_W            = 8;
    localparam int PROD_W            = 32;

    // 65535 * 65535, the denominator of a full-scale product
    localparam logic [63:0] FULL_SQ = 64'd4294836225;

    // chroma and match term, both over 65535^2
    typedef struct packed {
        logic [PROD_W-1:0] match;
        logic [PROD_W-1:0] chroma;
    } h2r_mix_t;

    // hue units in one 60-degree sector
    function automatic int sector_units(input int frac_bits);
        return 60 << frac_bits;
    endfunction

    // bits needed to hold 0 .. sector_units inclusive
    function automatic int units_width(input int frac_bits);
        return $clog2((60 << frac_bits) + 1);
    endfunction

    // common denominator 65535^2 * sector_units
    function automatic logic [63:0] den_of(input int frac_bits);
        return FULL_SQ * (64'd60 << frac_bits);
    endfunction

endpackage

// File: sv/h2r_hue_front.sv
// Front stages: hue sector and in-sector weight, chroma and match term.
// Three register stages; depends on h2r_pkg.
module h2r_hue_front
    import h2r_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
    localparam int SW = units_width(HUE_FRAC_BITS)
) (
    input  logic              clk,
    input  logic [2:0]        adv,
    input  logic [HUE_W-1:0]  hue_angle,
    input  logic [FRAC_W-1:0] saturation_level,
    input  logic [FRAC_W-1:0] brightness,
    output h2r_mix_t          mix,
    output logic [SW-1:0]     w_red,
    output logic [SW-1:0]     w_green,
    output logic [SW-1:0]     w_blue
);

    localparam int SU    = sector_units(HUE_FRAC_BITS);
    localparam int PAIR  = 2 * SU;
    localparam int POS_W = $clog2(PAIR);
    // ceil(2^16 / 15): exact floor(t / 15) for t below 4096
    localparam logic [12:0] RECIP_15 = 13'd4370;

    localparam logic [2:0] SECT_RED     = 3'd0;
    localparam logic [2:0] SECT_YELLOW  = 3'd1;
    localparam logic [2:0] SECT_GREEN   = 3'd2;
    localparam logic [2:0] SECT_CYAN    = 3'd3;
    localparam logic [2:0] SECT_BLUE    = 3'd4;
    localparam logic [2:0] SECT_MAGENTA = 3'd5;

    logic [HUE_W-1:0]  hue0_reg;
    logic [8:0]        q0_reg;
    logic [2:0]        sect0_reg;
    logic [PROD_W-1:0] chroma0_reg;
    logic [FRAC_W-1:0] val0_reg;
    logic [11:0]       t0;
    logic [24:0]       q0_prod;
    logic [2:0]        sect0_next;
    logic [31:0]       hue_wide;

    logic [POS_W-1:0]  pos1_reg;
    logic [POS_W-1:0]  pos1_next;
    logic [2:0]        sect1_reg;
    logic [PROD_W-1:0] chroma1_reg;
    logic [PROD_W-1:0] match1_reg;
    logic [PROD_W-1:0] match1_next;

    logic [SW-1:0]     weight2;
    logic [SW-1:0]     w_full;
    logic [SW-1:0]     w_red_next;
    logic [SW-1:0]     w_green_next;
    logic [SW-1:0]     w_blue_next;
    h2r_mix_t          mix_reg;
    logic [SW-1:0]     w_red_reg;
    logic [SW-1:0]     w_green_reg;
    logic [SW-1:0]     w_blue_reg;

    // Stage 0: pair index by reciprocal, sector by threshold compare
    assign hue_wide = 32'(hue_angle);
    assign t0       = 12'(hue_angle >> (HUE_FRAC_BITS + 3));
    assign q0_prod  = 25'(t0) * 25'(RECIP_15);

    always_comb
    begin
        if (hue_wide >= 32'(5 * SU))
        begin
            sect0_next = SECT_MAGENTA;
        end
        else if (hue_wide >= 32'(4 * SU))
        begin
            sect0_next = SECT_BLUE;
        end
        else if (hue_wide >= 32'(3 * SU))
        begin
            sect0_next = SECT_CYAN;
        end
        else if (hue_wide >= 32'(2 * SU))
        begin
            sect0_next = SECT_GREEN;
        end
        else if (hue_wide >= 32'(SU))
        begin
            sect0_next = SECT_YELLOW;
        end
        else
        begin
            sect0_next = SECT_RED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            hue0_reg    <= hue_angle;
            q0_reg      <= q0_prod[24:16];
            sect0_reg   <= sect0_next;
            chroma0_reg <= PROD_W'(saturation_level) * PROD_W'(brightness);
            val0_reg    <= brightness;
        end
    end

    // Stage 1: position within the sector pair, match = v*65535 - chroma
    assign pos1_next   = POS_W'(32'(hue0_reg) - 32'(q0_reg) * 32'(PAIR));
    assign match1_next = (PROD_W'(val0_reg) << FRAC_W) - PROD_W'(val0_reg) - chroma0_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            pos1_reg    <= pos1_next;
            sect1_reg   <= sect0_reg;
            chroma1_reg <= chroma0_reg;
            match1_reg  <= match1_next;
        end
    end

    // Stage 2: fold the position into a weight and order the components
    assign w_full = SW'(SU);

    always_comb
    begin
        if (32'(pos1_reg) < 32'(SU))
        begin
            weight2 = SW'(pos1_reg);
        end
        else
        begin
            weight2 = SW'(32'(PAIR) - 32'(pos1_reg));
        end
    end

    always_comb
    begin
        unique case (sect1_reg)
            SECT_RED:
            begin
                w_red_next = w_full; w_green_next = weight2; w_blue_next = '0;
            end
            SECT_YELLOW:
            begin
                w_red_next = weight2; w_green_next = w_full; w_blue_next = '0;
            end
            SECT_GREEN:
            begin
                w_red_next = '0; w_green_next = w_full; w_blue_next = weight2;
            end
            SECT_CYAN:
            begin
                w_red_next = '0; w_green_next = weight2; w_blue_next = w_full;
            end
            SECT_BLUE:
            begin
                w_red_next = weight2; w_green_next = '0; w_blue_next = w_full;
            end
            default:
            begin
                w_red_next = w_full; w_green_next = '0; w_blue_next = weight2;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            mix_reg.match  <= match1_reg;
            mix_reg.chroma <= chroma1_reg;
            w_red_reg      <= w_red_next;
            w_green_reg    <= w_green_next;
            w_blue_reg     <= w_blue_next;
        end
    end

    assign mix     = mix_reg;
    assign w_red   = w_red_reg;
    assign w_green = w_green_reg;
    assign w_blue  = w_blue_reg;

endmodule

// File: sv/h2r_round_div.sv
// Three-stage reciprocal divider by the constant 2*D with a one-step correction.
// Yields the rounded 8-bit component; depends on h2r_pkg.
module h2r_round_div
    import h2r_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
    localparam int X_W = PROD_W + units_width(HUE_FRAC_BITS) + 9
) (
    input  logic              clk,
    input  logic [2:0]        adv,
    input  logic [X_W-1:0]    dividend,
    output logic [COMP_W-1:0] quotient
);

    localparam int          TOP_W   = 24;
    localparam int          SHIFT   = X_W - TOP_W;
    localparam int          FRAC_K  = 26;
    localparam int          RECIP_W = 16;
    localparam int          PR_W    = TOP_W + RECIP_W;
    localparam logic [63:0] DEN2    = den_of(HUE_FRAC_BITS) << 1;
    // floor(2^(FRAC_K + SHIFT) / 2D): the estimate is the quotient or one below it
    localparam logic [63:0]        RECIP_FULL = (64'd1 << (FRAC_K + SHIFT)) / DEN2;
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_FULL);

    logic [TOP_W-1:0]  top_bits;
    logic [PR_W-1:0]   prod_reg;
    logic [X_W-1:0]    x_a_reg;

    logic [COMP_W-1:0] est_next;
    logic [COMP_W:0]   est_inc;
    logic [63:0]       bound_next;
    logic [COMP_W-1:0] est_reg;
    logic [63:0]       bound_reg;
    logic [X_W-1:0]    x_b_reg;

    logic              take;
    logic [COMP_W-1:0] quo_next;
    logic [COMP_W-1:0] quo_reg;

    // Stage A: multiply the top dividend bits by the reciprocal
    assign top_bits = dividend[X_W-1:SHIFT];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg <= PR_W'(top_bits) * PR_W'(RECIP);
            x_a_reg  <= dividend;
        end
    end

    // Stage B: form the bound (estimate + 1) * 2D
    assign est_next   = prod_reg[FRAC_K +: COMP_W];
    assign est_inc    = (COMP_W+1)'(est_next) + (COMP_W+1)'(1);
    assign bound_next = 64'(est_inc) * DEN2;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            est_reg   <= est_next;
            bound_reg <= bound_next;
            x_b_reg   <= x_a_reg;
        end
    end

    // Stage C: bump the estimate when the dividend reaches the bound
    assign take     = 64'(x_b_reg) >= bound_reg;
    assign quo_next = est_reg + COMP_W'(take);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

// File: sv/h2r_lane.sv
// One color lane: numerator match*S + chroma*weight, scale by 255 with half-up bias,
// then the constant divider. Depends on h2r_pkg and h2r_round_div.
module h2r_lane
    import h2r_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
    localparam int SW = units_width(HUE_FRAC_BITS)
) (
    input  logic              clk,
    input  logic [5:0]        adv,
    input  h2r_mix_t          mix,
    input  logic [SW-1:0]     weight,
    output logic [COMP_W-1:0] comp
);

    localparam int NUM_W = PROD_W + SW;
    localparam int X_W   = NUM_W + 9;
    localparam int SU    = sector_units(HUE_FRAC_BITS);

    logic [NUM_W-1:0] ms_reg;
    logic [NUM_W-1:0] cw_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;
    logic [X_W-1:0]   x_reg;
    logic [X_W-1:0]   x_next;

    // Products of match and chroma with their sector weights
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ms_reg <= NUM_W'(mix.match) * NUM_W'(SU);
            cw_reg <= NUM_W'(mix.chroma) * NUM_W'(weight);
        end
    end

    // Sum into the component numerator over D
    assign num_next = ms_reg + cw_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            num_reg <= num_next;
        end
    end

    // 510 * num + D, so that dividing by 2D rounds half up
    assign x_next = (X_W'(num_reg) << 9) - (X_W'(num_reg) << 1)
                    + X_W'(den_of(HUE_FRAC_BITS));

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            x_reg <= x_next;
        end
    end

    h2r_round_div #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .adv      (adv[5:3]),
        .dividend (x_reg),
        .quotient (comp)
    );

endmodule

// File: sv/hsv_to_rgb_converter.sv
// HSV to 8-bit RGB converter, nine register stages deep.
// One request per cycle while out_stall is low; a held out_stall stops the full stages, and
// in_stall rises once every stage up to the first holds data.
// Depth: three front stages, three numerator stages and a three-stage reciprocal divide.
// A stage takes new data whenever it is empty or its successor moves, so bubbles close up.
// rst_n (asynchronous, active low) clears all stage valid bits; data registers hold.
module hsv_to_rgb_converter
    import h2r_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [HUE_W-1:0]  hue_angle,
    input  logic [FRAC_W-1:0] saturation_level,
    input  logic [FRAC_W-1:0] brightness,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [COMP_W-1:0] red_out,
    output logic [COMP_W-1:0] green_out,
    output logic [COMP_W-1:0] blue_out
);

    localparam int SW         = units_width(HUE_FRAC_BITS);
    localparam int NUM_STAGES = 9;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   ready;
    h2r_mix_t              mix;
    logic [SW-1:0]         w_red;
    logic [SW-1:0]         w_green;
    logic [SW-1:0]         w_blue;

    // Advance a stage when it is empty or its successor advances
    assign ready[NUM_STAGES] = !out_stall;

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_ready
        assign ready[i] = !valid_reg[i] || ready[i+1];
    end

    assign valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    h2r_hue_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_front (
        .clk              (clk),
        .adv              (ready[2:0]),
        .hue_angle        (hue_angle),
        .saturation_level (saturation_level),
        .brightness       (brightness),
        .mix              (mix),
        .w_red            (w_red),
        .w_green          (w_green),
        .w_blue           (w_blue)
    );

    h2r_lane #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_lane_red (
        .clk    (clk),
        .adv    (ready[NUM_STAGES-1:3]),
        .mix    (mix),
        .weight (w_red),
        .comp   (red_out)
    );

    h2r_lane #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_lane_green (
        .clk    (clk),
        .adv    (ready[NUM_STAGES-1:3]),
        .mix    (mix),
        .weight (w_green),
        .comp   (green_out)
    );

    h2r_lane #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_lane_blue (
        .clk    (clk),
        .adv    (ready[NUM_STAGES-1:3]),
        .mix    (mix),
        .weight (w_blue),
        .comp   (blue_out)
    );

endmodule

// File: tb/hsv_to_rgb_converter_test.sv
// Self-checking bench for hsv_to_rgb_converter: random bursts of HSV requests, a stalling sink.
// Expected RGB triples come from an exact integer color model kept in a small scoreboard class.
// Depends on h2r_pkg and the hsv_to_rgb_converter RTL.
module hsv_to_rgb_converter_test
    import h2r_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_REQUESTS = 1850;
    localparam int          IDLE_LIMIT      = 1000;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int          REPORT_CAP      = 10;
    localparam int unsigned SECTOR_SPAN     = 60 << HUE_FRAC_BITS_DEF;
    localparam int unsigned HUE_TOP         = 6 * SECTOR_SPAN - 1;

    // sink stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_RUNS   = 2;
    localparam int STALL_TOGGLE = 3;

    // hue sectors, named by the primary that holds chroma and the one that rises or falls
    typedef enum int unsigned {
        SEC_RED_RISING_GREEN  = 0,
        SEC_GREEN_FALLING_RED = 1,
        SEC_GREEN_RISING_BLUE = 2,
        SEC_BLUE_FALLING_GRN  = 3,
        SEC_BLUE_RISING_RED   = 4
    } hue_sector_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] val;
    } hsv_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        hsv_t color;
        rgb_t rgb;
    } rgb_expect_t;

    class rgb_scoreboard;
        rgb_expect_t expected_rgb[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        // scale num/den by 255 and round half up
        static function logic [COMP_W-1:0] to_8bit(longint unsigned num, longint unsigned den);
            longint unsigned q;
            q = (510 * num + den) / (2 * den);
            return q[COMP_W-1:0];
        endfunction

        // exact HSV to RGB over the common denominator 65535^2 * sector span
        static function rgb_t hsv_to_rgb(hsv_t c);
            longint unsigned h, s, v, den, chroma, match_term, sector, pos, fold_dist, weight;
            longint unsigned n_max, n_min, n_mid, nr, ng, nb;
            rgb_t res;
            h = c.hue;
            s = c.sat;
            v = c.val;
            den = 64'd65535 * 64'd65535 * SECTOR_SPAN;
            chroma = s * v;
            match_term = v * 65535 - chroma;
            sector = h / SECTOR_SPAN;
            pos = h % (2 * SECTOR_SPAN);
            fold_dist = (pos >= SECTOR_SPAN) ? (pos - SECTOR_SPAN) : (SECTOR_SPAN - pos);
            weight = SECTOR_SPAN - fold_dist;
            n_max = v * 65535 * SECTOR_SPAN;
            n_min = match_term * SECTOR_SPAN;
            n_mid = n_min + chroma * weight;
            // order components by sector; hues past the fifth sector stay in the last one
            case (sector)
                SEC_RED_RISING_GREEN:
                begin
                    nr = n_max; ng = n_mid; nb = n_min;
                end
                SEC_GREEN_FALLING_RED:
                begin
                    nr = n_mid; ng = n_max; nb = n_min;
                end
                SEC_GREEN_RISING_BLUE:
                begin
                    nr = n_min; ng = n_max; nb = n_mid;
                end
                SEC_BLUE_FALLING_GRN:
                begin
                    nr = n_min; ng = n_mid; nb = n_max;
                end
                SEC_BLUE_RISING_RED:
                begin
                    nr = n_mid; ng = n_min; nb = n_max;
                end
                default:
                begin
                    nr = n_max; ng = n_min; nb = n_mid;
                end
            endcase
            res.red   = to_8bit(nr, den);
            res.green = to_8bit(ng, den);
            res.blue  = to_8bit(nb, den);
            return res;
        endfunction

        function void note_request(hsv_t c);
            rgb_expect_t e;
            e.color = c;
            e.rgb   = hsv_to_rgb(c);
            expected_rgb.push_back(e);
        endfunction

        function void check_result(rgb_t got);
            rgb_expect_t e;
            if (expected_rgb.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("unexpected rgb %0d,%0d,%0d with no request pending",
                             got.red, got.green, got.blue);
            end
            else
            begin
                e = expected_rgb.pop_front();
                if (got !== e.rgb)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("mismatch hsv %0d/%0d/%0d exp %0d,%0d,%0d got %0d,%0d,%0d",
                                 e.color.hue, e.color.sat, e.color.val,
                                 e.rgb.red, e.rgb.green, e.rgb.blue,
                                 got.red, got.green, got.blue);
                end
            end
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [HUE_W-1:0]  hue_angle = '0;
    logic [FRAC_W-1:0] saturation_level = '0;
    logic [FRAC_W-1:0] brightness = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [COMP_W-1:0] red_out;
    logic [COMP_W-1:0] green_out;
    logic [COMP_W-1:0] blue_out;

    rgb_scoreboard sb = new();
    int            idle_cycles = 0;
    int            stall_mode = 0;
    int            stall_left = 0;

    hsv_to_rgb_converter u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .hue_angle        (hue_angle),
        .saturation_level (saturation_level),
        .brightness       (brightness),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .red_out          (red_out),
        .green_out        (green_out),
        .blue_out         (blue_out)
    );

    always #4 clk = ~clk;

    // sample both handshakes at the rising edge; end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
                sb.note_request('{hue: hue_angle, sat: saturation_level, val: brightness});
            if (out_valid && !out_stall)
                sb.check_result('{red: red_out, green: green_out, blue: blue_out});
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("hsv_to_rgb_converter_test failed");
                $finish;
            end
        end
    end

    // sink stall pattern: free, random, long runs, or alternating, picked anew at random intervals
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(STALL_NONE, STALL_TOGGLE);
            stall_left <= $urandom_range(32, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 30);
            STALL_RUNS:   out_stall <= ((stall_left % 32) < 20);
            default:      out_stall <= stall_left[0];
        endcase
    end

    // present one request and hold it until accepted
    task automatic send_color(input logic [HUE_W-1:0] h, input logic [FRAC_W-1:0] s,
                              input logic [FRAC_W-1:0] v);
        @(negedge clk);
        in_valid         <= 1'b1;
        hue_angle        <= h;
        saturation_level <= s;
        brightness       <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drop valid for an idle gap set by n; scramble the idle payload
    task automatic idle_for(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid         <= 1'b0;
            hue_angle        <= HUE_W'($urandom);
            saturation_level <= FRAC_W'($urandom);
            brightness       <= FRAC_W'($urandom);
        end
    endtask

    function automatic logic [FRAC_W-1:0] pick_frac();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return FRAC_W'($urandom_range(0, 255));
            3:       return FRAC_W'(32'hFFFF - $urandom_range(0, 255));
            4:       return FRAC_W'(32'h8000 - $urandom_range(0, 1));
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    function automatic logic [HUE_W-1:0] pick_hue();
        int h;
        case ($urandom_range(0, 9))
            7:
            begin
                // land on or next to a sector boundary
                h = int'($urandom_range(0, 8) * SECTOR_SPAN + $urandom_range(0, 4)) - 2;
                if (h < 0) h = 0;
                if (h > 32767) h = 32767;
                return HUE_W'(h);
            end
            8:       return HUE_W'($urandom_range(HUE_TOP + 1, 32767));
            9:       return HUE_W'($urandom);
            default: return HUE_W'($urandom_range(0, HUE_TOP));
        endcase
    endfunction

    initial
    begin
        int sent;
        int burst;
        sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // black, white, gray and full-scale colors at each sector boundary
        send_color(15'd0, 16'd0, 16'd0);
        send_color(15'd0, 16'd0, 16'hFFFF);
        send_color(15'd0, 16'd0, 16'h8000);
        send_color(15'd0, 16'hFFFF, 16'hFFFF);
        send_color(HUE_W'(SECTOR_SPAN), 16'hFFFF, 16'hFFFF);
        send_color(HUE_W'(2 * SECTOR_SPAN), 16'hFFFF, 16'hFFFF);
        idle_for(2);
        send_color(HUE_W'(3 * SECTOR_SPAN), 16'hFFFF, 16'hFFFF);
        send_color(HUE_W'(4 * SECTOR_SPAN), 16'hFFFF, 16'hFFFF);
        send_color(HUE_W'(5 * SECTOR_SPAN), 16'hFFFF, 16'hFFFF);
        // just short of a boundary, mid sector, and top of the nominal range
        send_color(HUE_W'(SECTOR_SPAN - 1), 16'hFFFF, 16'hFFFF);
        send_color(HUE_W'(SECTOR_SPAN / 2), 16'hFFFF, 16'hFFFF);
        send_color(HUE_W'(HUE_TOP), 16'hFFFF, 16'hFFFF);
        send_color(HUE_W'(HUE_TOP), 16'h0001, 16'hFFFF);
        idle_for(1);
        // hues at and past 360 degrees keep the last branch
        send_color(HUE_W'(HUE_TOP + 1), 16'hFFFF, 16'hFFFF);
        send_color(HUE_W'(7 * SECTOR_SPAN), 16'hFFFF, 16'h8000);
        send_color(HUE_W'(8 * SECTOR_SPAN + 100), 16'hC000, 16'hFFFF);
        send_color(15'h7FFF, 16'hFFFF, 16'hFFFF);
        send_color(15'h7FFF, 16'h0000, 16'h0000);
        // tiny value, tiny saturation, rounding near half a step
        send_color(15'd1, 16'hFFFF, 16'd1);
        send_color(15'd1234, 16'd1, 16'hFFFF);
        send_color(15'd0, 16'd0, 16'd128);
        send_color(15'd0, 16'd0, 16'd385);
        send_color(15'h2AAA, 16'h5555, 16'hAAAA);

        // random bursts with random gaps between them
        while (sent < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(1, 48);
            repeat (burst)
            begin
                send_color(pick_hue(), pick_frac(), pick_frac());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 12));
        end
        idle_for(1);

        // wait until every expected result is checked, then run on so that a stray extra result is caught
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("hsv_to_rgb_converter_test passed");
        else
            $display("hsv_to_rgb_converter_test failed");
        $finish;
    end

endmodule
